>>> src/tsdc_pkg.sv
// ----------------------------------------------------------------------------
// tsdc_pkg: shared definitions for the tachometer speed control
// Field widths, register indexes, reset values, status codes and the
// configuration bundle used by the control, divider and power modules.
// ----------------------------------------------------------------------------
package tsdc_pkg;

    // Field widths
    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int RPM_W      = 16;
    localparam int DRIVE_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int POWER_W    = 9;
    localparam int STEP_W     = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Divider: constant dividend, one quotient bit per cycle
    localparam int NUM_W = 26;
    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [NUM_W-1:0] RPM_NUMERATOR = NUM_W'(60000000);

    // Power limits in half units
    localparam logic [POWER_W-1:0] INIT_POWER_HALVES = POWER_W'(200);
    localparam int POWER_MAX_HALVES = 510;
    localparam int POWER_MIN_HALVES = 2;

    // Configuration reset values
    localparam logic [SAMPLE_W-1:0] THRESHOLD_RST = SAMPLE_W'(600);
    localparam logic [RPM_W-1:0]    TARGET_RST    = RPM_W'(1500);
    localparam logic [RPM_W-1:0]    DEADBAND_RST  = RPM_W'(100);
    localparam logic [STEP_W-1:0]   STEP_RST      = STEP_W'(1);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_TARGET    = 2'd1,
        CFG_DEADBAND  = 2'd2,
        CFG_STEP      = 2'd3
    } cfg_idx_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL      = 2'd0,
        ST_CLAMP_HIGH  = 2'd1,
        ST_CLAMP_ZERO  = 2'd2,
        ST_ZERO_PERIOD = 2'd3
    } status_t;

    // Configuration bundle
    typedef struct packed {
        logic [SAMPLE_W-1:0] threshold;
        logic [RPM_W-1:0]    target_rpm;
        logic [RPM_W-1:0]    deadband;
        logic [STEP_W-1:0]   step_halves;
    } cfg_t;

    // Divider handshake
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> src/tach_speed_deadband_control_unit.sv
// ----------------------------------------------------------------------------
// tach_speed_deadband_control_unit: tachometer speed control with deadband
// Detects marks in the sensor stream, measures the period between a pair of
// marks, turns it into rpm with a serial divider and steps motor power.
// ----------------------------------------------------------------------------
//  channel  signals                         direction  role
//  in       in_valid/in_ready, sample,      sink       sensor sample request
//           time_us
//  out      out_valid/out_ready, rpm,       source     measurement result
//           drive, status
//  cfg      cfg_we, cfg_index, cfg_data     sink       register write
//
// A sample that closes no measurement is handled in its accept alone; a zero
// period goes from the accept straight to the output load. A measurement
// runs the accept, the bit-serial divider (one quotient bit per cycle),
// the quotient take, the power update and a load once the output is free.
// in_ready is high only while no request is in work; the result register
// lets the next request in while a result waits on out_ready.
// Reset is asynchronous, active low: armed, no first mark, power 100.
// ----------------------------------------------------------------------------
module tach_speed_deadband_control_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [tsdc_pkg::SAMPLE_W-1:0]     sample,
    input  logic [tsdc_pkg::TIME_W-1:0]       time_us,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [tsdc_pkg::RPM_W-1:0]        rpm,
    output logic [tsdc_pkg::DRIVE_W-1:0]      drive,
    output logic [tsdc_pkg::STATUS_W-1:0]     status,
    input  logic                              cfg_we,
    input  logic [tsdc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tsdc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_PWR,
        S_LOAD
    } state_t;

    state_t                          state_reg;
    tsdc_pkg::cfg_t                  cfg_reg;
    logic                            armed_reg;
    logic                            have_first_reg;
    logic [tsdc_pkg::TIME_W-1:0]     first_mark_reg;
    logic                            zero_reg;
    logic [tsdc_pkg::RPM_W-1:0]      res_rpm_reg;
    logic                            out_valid_reg;
    logic [tsdc_pkg::RPM_W-1:0]      rpm_reg;
    logic [tsdc_pkg::DRIVE_W-1:0]    drive_reg;
    tsdc_pkg::status_t               status_reg;

    logic                            accept;
    logic                            is_above;
    logic                            is_mark;
    logic [tsdc_pkg::TIME_W-1:0]     period;
    logic                            zero_period;
    logic                            div_start;
    logic                            load_res;
    tsdc_pkg::div_stat_t             div_stat;
    logic [tsdc_pkg::NUM_W-1:0]      div_quot;
    logic [tsdc_pkg::RPM_W-1:0]      rpm_sat;
    logic [tsdc_pkg::POWER_W-1:0]    pwr_power;
    tsdc_pkg::status_t               pwr_status;

    // Classify the incoming sample
    always_comb
    begin
        accept      = in_valid && in_ready;
        is_above    = sample > cfg_reg.threshold;
        is_mark     = (sample < cfg_reg.threshold) && armed_reg;
        period      = time_us - first_mark_reg;
        zero_period = (period == '0);
        div_start   = accept && is_mark && have_first_reg && !zero_period;
    end

    // Load the result once the output register is free
    assign load_res = (state_reg == S_LOAD) && (!out_valid_reg || out_ready);

    // Saturate the quotient to the rpm range
    assign rpm_sat = (div_quot[tsdc_pkg::NUM_W-1:tsdc_pkg::RPM_W] != '0)
                     ? '1 : div_quot[tsdc_pkg::RPM_W-1:0];

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold   <= tsdc_pkg::THRESHOLD_RST;
            cfg_reg.target_rpm  <= tsdc_pkg::TARGET_RST;
            cfg_reg.deadband    <= tsdc_pkg::DEADBAND_RST;
            cfg_reg.step_halves <= tsdc_pkg::STEP_RST;
        end
        else if (cfg_we)
        begin
            unique case (tsdc_pkg::cfg_idx_t'(cfg_index))
                tsdc_pkg::CFG_THRESHOLD: cfg_reg.threshold   <= cfg_data[tsdc_pkg::SAMPLE_W-1:0];
                tsdc_pkg::CFG_TARGET:    cfg_reg.target_rpm  <= cfg_data[tsdc_pkg::RPM_W-1:0];
                tsdc_pkg::CFG_DEADBAND:  cfg_reg.deadband    <= cfg_data[tsdc_pkg::RPM_W-1:0];
                tsdc_pkg::CFG_STEP:      cfg_reg.step_halves <= cfg_data[tsdc_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: mark detection, divide, power update, output load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            armed_reg      <= 1'b1;
            have_first_reg <= 1'b0;
            first_mark_reg <= '0;
            zero_reg       <= 1'b0;
            res_rpm_reg    <= '0;
            out_valid_reg  <= 1'b0;
            rpm_reg        <= '0;
            drive_reg      <= '0;
            status_reg     <= tsdc_pkg::ST_NORMAL;
        end
        else
        begin
            // Raise valid on a load, drop the result once taken
            if (load_res)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        priority if (is_above)
                        begin
                            armed_reg <= 1'b1;
                        end
                        else if (is_mark)
                        begin
                            armed_reg <= 1'b0;
                            if (!have_first_reg)
                            begin
                                have_first_reg <= 1'b1;
                                first_mark_reg <= time_us;
                            end
                            else
                            begin
                                have_first_reg <= 1'b0;
                                if (zero_period)
                                begin
                                    zero_reg    <= 1'b1;
                                    res_rpm_reg <= '0;
                                    state_reg   <= S_LOAD;
                                end
                                else
                                begin
                                    zero_reg  <= 1'b0;
                                    state_reg <= S_DIV;
                                end
                            end
                        end
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        res_rpm_reg <= rpm_sat;
                        state_reg   <= S_PWR;
                    end
                end
                S_PWR:
                begin
                    state_reg <= S_LOAD;
                end
                S_LOAD:
                begin
                    // Hold until the output register is free
                    if (load_res)
                    begin
                        rpm_reg       <= res_rpm_reg;
                        drive_reg     <= pwr_power[tsdc_pkg::POWER_W-1:1];
                        status_reg    <= zero_reg ? tsdc_pkg::ST_ZERO_PERIOD : pwr_status;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    tsdc_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (period),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    tsdc_pwr u_pwr (
        .clk    (clk),
        .rst_n  (rst_n),
        .update (state_reg == S_PWR),
        .rpm    (res_rpm_reg),
        .cfg    (cfg_reg),
        .power  (pwr_power),
        .status (pwr_status)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign rpm       = rpm_reg;
    assign drive     = drive_reg;
    assign status    = status_reg;

    // The divider runs for the whole divide phase
    a_div_in_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> div_stat.busy || div_stat.done)
        else $error("divide phase without a running divider");

    // A new result appears only from the load step
    a_result_from_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_LOAD))
        else $error("result loaded outside the load step");

endmodule

>>> src/tsdc_div.sv
// ----------------------------------------------------------------------------
// tsdc_div: bit-serial restoring divider
// Divides the constant rpm numerator by the measured period, shifting the
// dividend in one bit and the quotient out one bit per cycle.
// ----------------------------------------------------------------------------
module tsdc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tsdc_pkg::TIME_W-1:0]       divisor,
    output tsdc_pkg::div_stat_t               stat,
    output logic [tsdc_pkg::NUM_W-1:0]        quot
);

    logic [tsdc_pkg::TIME_W-1:0]  rem_reg;
    logic [tsdc_pkg::TIME_W-1:0]  div_reg;
    logic [tsdc_pkg::NUM_W-1:0]   num_reg;
    logic [tsdc_pkg::NUM_W-1:0]   quot_reg;
    logic [tsdc_pkg::CNT_W-1:0]   cnt_reg;
    logic                         done_reg;

    logic [tsdc_pkg::TIME_W:0]    trial;
    logic [tsdc_pkg::TIME_W:0]    diff;
    logic                         fits;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial = {rem_reg, num_reg[tsdc_pkg::NUM_W-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
    end

    // Load on start, then advance one quotient bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= tsdc_pkg::CNT_W'(tsdc_pkg::NUM_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == tsdc_pkg::CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            div_reg  <= divisor;
            num_reg  <= tsdc_pkg::RPM_NUMERATOR;
            quot_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= fits ? diff[tsdc_pkg::TIME_W-1:0] : trial[tsdc_pkg::TIME_W-1:0];
            num_reg  <= {num_reg[tsdc_pkg::NUM_W-2:0], 1'b0};
            quot_reg <= {quot_reg[tsdc_pkg::NUM_W-2:0], fits};
        end
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign quot      = quot_reg;

    // A start always leads to a busy divider
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> stat.busy)
        else $error("divider not busy after start");

    // Done follows the last busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> !stat.busy && $past(stat.busy))
        else $error("divider done without a finished run");

endmodule

>>> src/tsdc_pwr.sv
// ----------------------------------------------------------------------------
// tsdc_pwr: power stepping with deadband and clamping
// Holds power in half units and steps it once per measurement, down when
// speed is below the band and up when above, then clamps to its range.
// ----------------------------------------------------------------------------
module tsdc_pwr (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          update,
    input  logic [tsdc_pkg::RPM_W-1:0]    rpm,
    input  tsdc_pkg::cfg_t                cfg,
    output logic [tsdc_pkg::POWER_W-1:0]  power,
    output tsdc_pkg::status_t             status
);

    logic [tsdc_pkg::POWER_W-1:0]  power_reg;
    logic [tsdc_pkg::POWER_W-1:0]  power_next;
    tsdc_pkg::status_t             status_reg;
    tsdc_pkg::status_t             status_next;

    logic signed [tsdc_pkg::RPM_W+1:0] band_lo;
    logic        [tsdc_pkg::RPM_W:0]   band_hi;
    logic                              below;
    logic                              above;
    logic signed [tsdc_pkg::POWER_W+1:0] stepped;

    // Compare against the band without wrapping, step and clamp
    always_comb
    begin
        band_lo = $signed({2'b00, cfg.target_rpm}) - $signed({2'b00, cfg.deadband});
        band_hi = {1'b0, cfg.target_rpm} + {1'b0, cfg.deadband};
        below   = $signed({2'b00, rpm}) < band_lo;
        above   = {1'b0, rpm} > band_hi;

        stepped = $signed({2'b00, power_reg});
        if (below)
        begin
            stepped = stepped - $signed({2'b00, cfg.step_halves});
        end
        else if (above)
        begin
            stepped = stepped + $signed({2'b00, cfg.step_halves});
        end

        status_next = tsdc_pkg::ST_NORMAL;
        power_next  = stepped[tsdc_pkg::POWER_W-1:0];
        if (stepped > $signed((tsdc_pkg::POWER_W+2)'(tsdc_pkg::POWER_MAX_HALVES)))
        begin
            power_next  = tsdc_pkg::POWER_W'(tsdc_pkg::POWER_MAX_HALVES);
            status_next = tsdc_pkg::ST_CLAMP_HIGH;
        end
        if (stepped < $signed((tsdc_pkg::POWER_W+2)'(tsdc_pkg::POWER_MIN_HALVES)))
        begin
            power_next  = '0;
            status_next = tsdc_pkg::ST_CLAMP_ZERO;
        end
    end

    // Hold power between measurements
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_reg  <= tsdc_pkg::INIT_POWER_HALVES;
            status_reg <= tsdc_pkg::ST_NORMAL;
        end
        else if (update)
        begin
            power_reg  <= power_next;
            status_reg <= status_next;
        end
    end

    assign power  = power_reg;
    assign status = status_reg;

    // Power stays in range and never rests at a single half unit
    a_power_range: assert property (@(posedge clk) disable iff (!rst_n)
        update |=> power_reg <= tsdc_pkg::POWER_W'(tsdc_pkg::POWER_MAX_HALVES)
                   && power_reg != tsdc_pkg::POWER_W'(1))
        else $error("power out of range after update");

endmodule
